/* hw/rtl/tfa_pkg.sv */
// Package for the thermal frame AGC/upscale block: sizes, types, commands.
// No dependencies.
package tfa_pkg;
    localparam int SourceWidth  = 160;
    localparam int SourceHeight = 120;
    localparam int ScaleFactor  = 5;
    localparam int FrameSize    = SourceWidth * SourceHeight;
    localparam int OutWidth     = SourceWidth * ScaleFactor;
    localparam int OutHeight    = SourceHeight * ScaleFactor;
    localparam int AddrW        = $clog2(FrameSize);
    localparam int IdxW         = $clog2(FrameSize + 1);
    localparam int SrcColW      = $clog2(SourceWidth);
    localparam int SrcRowW      = $clog2(SourceHeight);
    localparam int ScW          = (ScaleFactor > 1) ? $clog2(ScaleFactor) : 1;
    localparam logic [7:0] GreyTop = 8'd254;
    localparam logic [15:0] AgcRangeReset = 16'd200;

    typedef enum logic {CMD_LOAD = 1'b0, CMD_FETCH = 1'b1} t_cmd;

    typedef struct packed {
        logic       command;
        logic [15:0] pixel_value;
        logic       frame_start;
    } t_in_word;

    typedef struct packed {
        logic [7:0] grey_level;
        logic [9:0] output_row;
        logic [9:0] output_column;
        logic       last_pixel;
    } t_out_word;

    // controller -> datapath
    typedef struct packed {
        logic load;     // write pixel, update tracking
        logic fetch;    // advance read counters, issue memory read
        logic div_start;
        logic div_step;
        logic out_load;
    } t_ctrl;

    // datapath -> controller
    typedef struct packed {
        logic div_done;
    } t_stat;
endpackage

/* hw/rtl/tfa_if.sv */
// Valid/ready channel interfaces for the thermal AGC block.
// Depends on tfa_pkg.
interface tfa_in_if;
    logic valid;
    logic ready;
    tfa_pkg::t_in_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfa_out_if;
    logic valid;
    logic ready;
    tfa_pkg::t_out_word data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface tfa_cfg_if;
    logic valid;
    logic ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/tfa_datapath.sv */
// Datapath: frame memory, min/max tracking, read counters, restoring divider.
// Depends on tfa_pkg.
module tfa_datapath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  tfa_pkg::t_in_word i_word,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    input  tfa_pkg::t_ctrl    i_ctrl,
    output tfa_pkg::t_stat    o_stat,
    output tfa_pkg::t_out_word o_word
);
    import tfa_pkg::*;

    logic [15:0] r_mem [FrameSize];
    logic [15:0] r_rd;
    logic [15:0] r_min, r_max, r_agc;
    logic [IdxW-1:0] r_widx;
    logic [9:0] r_row, r_col;
    logic [SrcRowW-1:0] r_srow;
    logic [SrcColW-1:0] r_scol;
    logic [ScW-1:0] r_rsub, r_csub;
    logic [9:0] r_orow, r_ocol;
    logic r_olast;
    // divider
    logic [23:0] r_num;
    logic [16:0] r_rem;
    logic [15:0] r_den;
    logic [4:0]  r_cnt;
    logic        r_below;

    logic [IdxW-1:0] n_widx;
    logic [15:0] n_min, n_max, span, floor_span, range_v, diff;
    logic [16:0] trial;
    logic last_col, last_row;

    always_comb begin
        n_widx = i_word.frame_start ? '0 : r_widx;
        n_min  = i_word.frame_start ? 16'hFFFF : r_min;
        n_max  = i_word.frame_start ? 16'h0000 : r_max;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load && n_widx < IdxW'(FrameSize))
            r_mem[n_widx[AddrW-1:0]] <= i_word.pixel_value;
        if (i_ctrl.fetch)
            r_rd <= r_mem[AddrW'(r_srow * SourceWidth) + AddrW'(r_scol)];
    end

    assign last_col = (r_col == 10'(OutWidth - 1));
    assign last_row = (r_row == 10'(OutHeight - 1));
    assign span       = r_max - r_min;
    assign floor_span = (r_agc == '0) ? 16'd1 : r_agc;
    assign range_v    = (span < floor_span) ? floor_span : span;
    assign diff       = r_rd - r_min;
    assign trial      = {r_rem[15:0], r_num[23]} - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= 16'hFFFF; r_max <= '0; r_widx <= '0; r_agc <= AgcRangeReset;
            r_row <= '0; r_col <= '0; r_srow <= '0; r_scol <= '0;
            r_rsub <= '0; r_csub <= '0; r_cnt <= '0;
        end else begin
            if (i_cfg_we) r_agc <= i_cfg_data;
            if (i_ctrl.load) begin
                if (n_widx < IdxW'(FrameSize)) begin
                    r_widx <= n_widx + 1'b1;
                    r_min <= (i_word.pixel_value < n_min) ? i_word.pixel_value : n_min;
                    r_max <= (i_word.pixel_value > n_max) ? i_word.pixel_value : n_max;
                end else begin
                    r_widx <= n_widx; r_min <= n_min; r_max <= n_max;
                end
            end
            if (i_ctrl.fetch) begin
                r_orow <= r_row; r_ocol <= r_col; r_olast <= last_col && last_row;
                if (last_col) begin
                    r_col <= '0; r_scol <= '0; r_csub <= '0;
                    if (last_row) begin
                        r_row <= '0; r_srow <= '0; r_rsub <= '0;
                    end else begin
                        r_row <= r_row + 1'b1;
                        if (r_rsub == ScW'(ScaleFactor - 1)) begin
                            r_rsub <= '0; r_srow <= r_srow + 1'b1;
                        end else r_rsub <= r_rsub + 1'b1;
                    end
                end else begin
                    r_col <= r_col + 1'b1;
                    if (r_csub == ScW'(ScaleFactor - 1)) begin
                        r_csub <= '0; r_scol <= r_scol + 1'b1;
                    end else r_csub <= r_csub + 1'b1;
                end
            end
            if (i_ctrl.div_start) begin
                r_cnt <= 5'd24;
                r_rem <= '0;
                r_den <= range_v;
                r_below <= (r_rd <= r_min);
                r_num <= {diff, 8'd0} - {7'd0, diff, 1'b0}; // diff*254
            end else if (i_ctrl.div_step) begin
                r_cnt <= r_cnt - 1'b1;
                r_num <= {r_num[22:0], ~trial[16]};
                r_rem <= trial[16] ? {r_rem[15:0], r_num[23]} : trial;
            end
        end
    end

    assign o_stat.div_done = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.out_load) begin
            o_word.grey_level <= r_below ? 8'd0 :
                (r_num > 24'(GreyTop)) ? GreyTop : r_num[7:0];
            o_word.output_row <= r_orow;
            o_word.output_column <= r_ocol;
            o_word.last_pixel <= r_olast;
        end
    end

    a_out_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.out_load |-> (r_cnt == '0))
        else $error("output taken before divide done");
    a_widx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_widx <= IdxW'(FrameSize)))
        else $error("write index past frame");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctrl.load |-> !i_ctrl.fetch)
        else $error("load and fetch together");
endmodule

/* hw/rtl/tfa_ctrl.sv */
// Controller FSM: accepts words, sequences read, divide and output register.
// Depends on tfa_pkg.
module tfa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_cmd,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  tfa_pkg::t_stat i_stat,
    output tfa_pkg::t_ctrl o_ctrl
);
    import tfa_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_READ, S_DIV, S_LAST} t_state;
    t_state r_state;
    logic r_out_valid, acc;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign acc = i_in_valid && o_in_ready;

    always_comb begin
        o_ctrl = '0;
        o_ctrl.load  = acc && (i_in_cmd == CMD_LOAD);
        o_ctrl.fetch = acc && (i_in_cmd == CMD_FETCH);
        o_ctrl.div_start = (r_state == S_READ);
        o_ctrl.div_step  = (r_state == S_DIV) && !i_stat.div_done;
        o_ctrl.out_load  = (r_state == S_LAST) && (!r_out_valid || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_out_valid <= 1'b0;
        end else begin
            if (o_ctrl.out_load) r_out_valid <= 1'b1;
            else if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: if (o_ctrl.fetch) r_state <= S_READ;
                S_READ: r_state <= S_DIV;
                S_DIV:  if (i_stat.div_done) r_state <= S_LAST;
                S_LAST: if (o_ctrl.out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_hold_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> r_out_valid)
        else $error("pending word dropped");
    a_busy_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> !o_in_ready)
        else $error("accepting during divide");
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctrl.out_load |-> i_stat.div_done)
        else $error("divide not done");
endmodule

/* hw/rtl/thermal_frame_agc_upscale.sv */
// Top level: thermal frame store, min/max AGC and 5x nearest upscale.
// Depends on tfa_pkg, tfa_if, tfa_ctrl, tfa_datapath.
//
// channel | dir | word
// in      | in  | command, pixel_value, frame_start
// out     | out | grey_level, output_row, output_column, last_pixel
// cfg     | in  | span floor (16 b)
//
// Load: pixel write and min/max update. Fetch steps: memory read, divider setup,
// 24-step restoring divide of (pix-min)*254 by range, done, output register.
// Output register lets the next word in while a result waits.
// Reset: synchronous, active low; min 65535, max 0, counters 0, range 200.
// Frame memory is not cleared.
module thermal_frame_agc_upscale (
    input logic i_clk,
    input logic i_rst_n,
    tfa_in_if.sink    in_ch,
    tfa_out_if.source out_ch,
    tfa_cfg_if.sink   cfg_ch
);
    import tfa_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    assign cfg_ch.ready = 1'b1;

    tfa_ctrl u_ctrl (
        .i_clk, .i_rst_n,
        .i_in_valid(in_ch.valid), .i_in_cmd(in_ch.data.command),
        .o_in_ready(in_ch.ready),
        .o_out_valid(out_ch.valid), .i_out_ready(out_ch.ready),
        .i_stat(stat), .o_ctrl(ctrl)
    );

    tfa_datapath u_dp (
        .i_clk, .i_rst_n,
        .i_word(in_ch.data),
        .i_cfg_we(cfg_ch.valid), .i_cfg_data(cfg_ch.data),
        .i_ctrl(ctrl), .o_stat(stat), .o_word(out_ch.data)
    );
endmodule

/* sim/tfa_tb_if.sv */
// Testbench helpers: idle rate shared by driver and monitor.
// The channel interfaces come from the RTL (tfa_if.sv).
package tfa_tb_util;
    localparam int StallPct = 29;
endpackage

/* sim/testbench.sv */
// Testbench for thermal_frame_agc_upscale: loads frames, fetches enlarged pixels and
// checks every result against an in-bench AGC/upscale predictor.
// Depends on tfa_pkg, tfa_if and tfa_tb_util.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import tfa_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #10 i_clk = ~i_clk;

    tfa_in_if  in_ch ();
    tfa_out_if out_ch ();
    tfa_cfg_if cfg_ch ();

    thermal_frame_agc_upscale dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
    );

    // predictor state
    logic [15:0] frame_mem [FrameSize];
    logic [15:0] trk_min, trk_max, span_floor;
    int unsigned wr_idx, rd_row, rd_col;

    t_in_word  pending_words [$];
    t_out_word expected_px [$];
    int unsigned n_err, n_checked, n_loads;
    bit calm;   // no idling on either side while set

    task automatic report(input string what, input t_out_word got, input t_out_word exp);
        n_err++;
        $display("mismatch %s: got g%0d r%0d c%0d l%0d exp g%0d r%0d c%0d l%0d", what,
                 got.grey_level, got.output_row, got.output_column, got.last_pixel,
                 exp.grey_level, exp.output_row, exp.output_column, exp.last_pixel);
    endtask

    function automatic logic [7:0] agc_grey(input logic [15:0] pix);
        logic [16:0] rng;
        logic [16:0] flo;
        logic [31:0] q;
        rng = {1'b0, 16'(trk_max - trk_min)};
        flo = (span_floor == 16'd0) ? 17'd1 : {1'b0, span_floor};
        if (rng < flo) rng = flo;
        if (pix <= trk_min) return 8'd0;
        q = (32'(pix - trk_min) * 32'd254) / 32'(rng);
        return (q > 32'd254) ? GreyTop : q[7:0];
    endfunction

    // apply one accepted input word to the predictor
    task automatic predict_word(input t_in_word w);
        t_out_word o;
        int unsigned idx;
        if (w.command == CMD_LOAD) begin
            n_loads++;
            if (w.frame_start) begin
                trk_min = 16'hFFFF; trk_max = 16'h0; wr_idx = 0;
            end
            if (wr_idx < FrameSize) begin
                frame_mem[wr_idx] = w.pixel_value;
                wr_idx++;
                if (w.pixel_value < trk_min) trk_min = w.pixel_value;
                if (w.pixel_value > trk_max) trk_max = w.pixel_value;
            end
        end else begin
            idx = (rd_row / ScaleFactor) * SourceWidth + rd_col / ScaleFactor;
            o.grey_level = agc_grey(frame_mem[idx]);
            o.output_row = rd_row[9:0];
            o.output_column = rd_col[9:0];
            o.last_pixel = 1'b0;
            if (rd_col + 1 >= OutWidth) begin
                rd_col = 0;
                if (rd_row + 1 >= OutHeight) begin
                    rd_row = 0; o.last_pixel = 1'b1;
                end else begin
                    rd_row++;
                end
            end else begin
                rd_col++;
            end
            expected_px.push_back(o);
        end
    endtask

    // driver: next pending word, random idle cycles, word held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                predict_word(in_ch.data);
                void'(pending_words.pop_front());
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (pending_words.size() > 0 &&
                    (calm || $urandom_range(99) >= tfa_tb_util::StallPct)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.data  <= pending_words[0];
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: random backpressure and comparison
    always @(posedge i_clk) begin
        t_out_word exp;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                if (expected_px.size() == 0) begin
                    report("unexpected", out_ch.data, '0);
                end else begin
                    exp = expected_px.pop_front();
                    n_checked++;
                    if (out_ch.data !== exp) report("field", out_ch.data, exp);
                end
            end
            out_ch.ready <= calm || ($urandom_range(99) >= tfa_tb_util::StallPct);
        end
    end

    // pending words are consumed by the driver; wait for all of them and results
    task automatic drain();
        while (pending_words.size() != 0 || in_ch.valid || expected_px.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_span(input logic [15:0] v);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        span_floor = v;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic t_in_word ld(input logic [15:0] p, input bit fs);
        t_in_word w;
        w.command = CMD_LOAD; w.pixel_value = p; w.frame_start = fs;
        return w;
    endfunction

    function automatic t_in_word ft();
        t_in_word w;
        w.command = CMD_FETCH; w.pixel_value = 16'($urandom); w.frame_start = 1'($urandom);
        return w;
    endfunction

    // load one source row around a base with a random spread; the fetches of
    // this run stay in the top band of the enlarged image, which reads row 0 only
    task automatic queue_frame(input int kind);
        logic [15:0] base, spread;
        base = 16'($urandom);
        spread = (kind == 0) ? 16'($urandom_range(300)) : 16'($urandom);
        for (int i = 0; i < SourceWidth; i++)
            pending_words.push_back(ld(base + 16'($urandom_range(spread)), i == 0));
    endtask

    task automatic queue_fetches(input int n);
        for (int i = 0; i < n; i++) begin
            pending_words.push_back(ft());
            if ($urandom_range(9) == 0)     // stray loads between fetches grow the frame
                pending_words.push_back(ld(16'($urandom), 1'b0));
        end
    endtask

    initial begin
        logic [15:0] spans [4] = '{16'd1, 16'hFFFF, 16'd0, 16'd37};
        in_ch.valid = 1'b0; in_ch.data = '0;
        out_ch.ready = 1'b0;
        cfg_ch.valid = 1'b0; cfg_ch.data = '0;
        trk_min = 16'hFFFF; trk_max = 16'h0; wr_idx = 0; rd_row = 0; rd_col = 0;
        span_floor = AgcRangeReset;
        calm = 1'b0; n_err = 0; n_checked = 0; n_loads = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: one source row with extremes at the left, then first pixels
        pending_words.push_back(ld(16'h0000, 1'b1));
        pending_words.push_back(ld(16'hFFFF, 1'b0));
        pending_words.push_back(ld(16'h8000, 1'b0));
        for (int i = 3; i < SourceWidth; i++)
            pending_words.push_back(ld(16'($urandom), 1'b0));
        queue_fetches(16);
        drain();

        // several span settings, frames narrow and wide, quiet stretch in the middle
        for (int ph = 0; ph < 5; ph++) begin
            write_span(ph < 4 ? spans[ph] : 16'($urandom_range(1, 65535)));
            calm = (ph == 2);
            queue_frame(ph % 2);
            queue_fetches(25);
            drain();    // sender holds until every result is in
        end
        // frame restarted but not finished: stale pixels below the new minimum
        calm = 1'b0;
        write_span(AgcRangeReset);
        for (int i = 0; i < 40; i++)
            pending_words.push_back(ld(16'hF000 + 16'($urandom_range(4095)), i == 0));
        queue_fetches(20);
        drain();

        $display("covered %0d loads and %0d checked enlarged pixels", n_loads, n_checked);
        $display("span floors: 200, 1, 65535, 0, 37, one random, 200 again");
        if (n_err == 0 && expected_px.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        #200ms;
        $display("RESULT: ERROR");
        $finish;
    end
endmodule

/* thermal_frame_agc_upscale.f */
hw/rtl/tfa_pkg.sv
hw/rtl/tfa_if.sv
hw/rtl/tfa_datapath.sv
hw/rtl/tfa_ctrl.sv
hw/rtl/thermal_frame_agc_upscale.sv
sim/tfa_tb_if.sv
sim/testbench.sv
